// ----- rtl/dtv_pkg.sv -----
// Package for the date-time text validator: character codes, field indexes,
// range limits and the month length table shared by the parser and the checker.
// No dependencies.
package dtv_pkg;

   localparam int DTV_FIELD_BITS = 16;
   localparam int DTV_NUM_FIELDS = 5;
   localparam int DTV_YEAR_W     = 17;

   // Field slots, in the order they appear in the text
   localparam logic [2:0] DTV_FLD_HOUR   = 3'd0;
   localparam logic [2:0] DTV_FLD_MINUTE = 3'd1;
   localparam logic [2:0] DTV_FLD_DAY    = 3'd2;
   localparam logic [2:0] DTV_FLD_MONTH  = 3'd3;
   localparam logic [2:0] DTV_FLD_YEAR   = 3'd4;

   localparam logic [7:0] DTV_CHAR_NUL   = 8'd0;
   localparam logic [7:0] DTV_CHAR_SPACE = 8'd32;
   localparam logic [7:0] DTV_CHAR_COLON = 8'd58;
   localparam logic [7:0] DTV_CHAR_DOT   = 8'd46;
   localparam logic [7:0] DTV_DIGIT_LOW  = 8'd47;
   localparam logic [7:0] DTV_DIGIT_HIGH = 8'd58;

   localparam int DTV_MAX_HOUR   = 23;
   localparam int DTV_MAX_MINUTE = 59;
   localparam int DTV_MONTHS     = 12;
   localparam int DTV_YEAR_BASE  = 1900;
   localparam int DTV_FEBRUARY   = 2;
   // 400 = 16 * 25 and 100 = 4 * 25: the century tests reduce to divisibility by 25
   localparam int DTV_CENTURY_ODD = 25;

   // Days in a non-leap year's month, month numbered 1..12
   function automatic logic [4:0] dtv_month_days(input logic [3:0] month);
      logic [4:0] days;
      case (month)
         4'd2:    days = 5'd28;
         4'd4:    days = 5'd30;
         4'd6:    days = 5'd30;
         4'd9:    days = 5'd30;
         4'd11:   days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

   // Multiplicative inverse of an odd number modulo 2^64 (Newton iteration);
   // evaluated at elaboration only
   function automatic logic [63:0] dtv_odd_inverse(input logic [63:0] odd_value);
      logic [63:0] x;
      x = odd_value;
      for (int i = 0; i < 6; i++) begin
         x = x * (64'd2 - odd_value * x);
      end
      return x;
   endfunction

endpackage

// ----- rtl/dtv_req_if.sv -----
// Input channel of the date-time text validator: one text byte per transaction.
// No dependencies.
interface dtv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last;

   modport source (output valid, output text_byte, output last, input ready);
   modport sink   (input valid, input text_byte, input last, output ready);
endinterface

// ----- rtl/dtv_rsp_if.sv -----
// Result channel of the date-time text validator: one parsed date-time per transaction.
// No dependencies.
interface dtv_rsp_if;
   logic               valid;
   logic               ready;
   logic               valid_res;
   logic [4:0]         hour;
   logic [5:0]         minute;
   logic [4:0]         day_of_month;
   logic [3:0]         month_index;
   logic signed [16:0] years_since_1900;

   modport source (output valid, output valid_res, output hour, output minute,
                   output day_of_month, output month_index, output years_since_1900,
                   input ready);
   modport sink   (input valid, input valid_res, input hour, input minute,
                   input day_of_month, input month_index, input years_since_1900,
                   output ready);
endinterface

// ----- rtl/dtv_parser.sv -----
// Byte-wise tokenizer: splits the text into words and fields and accumulates digits.
// Registers one record (five fields plus a syntax flag) on the last byte.
// Depends on dtv_pkg and dtv_req_if.
module dtv_parser #(
   parameter int FIELD_BITS = dtv_pkg::DTV_FIELD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   dtv_req_if.sink               req_chan,
   output logic                  rec_valid_ff,
   output logic                  rec_ok_ff,
   output logic [FIELD_BITS-1:0] rec_field_ff [dtv_pkg::DTV_NUM_FIELDS],
   input  logic                  rec_ready
);
   import dtv_pkg::*;

   localparam int WIDE = FIELD_BITS + 4;

   logic [1:0]            word_cnt_ff, word_cnt_in;
   logic [2:0]            tok_cnt_ff, tok_cnt_in;
   logic                  in_tok_ff, in_tok_in;
   logic                  in_word_ff, in_word_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [FIELD_BITS-1:0] field_ff [DTV_NUM_FIELDS];
   logic [FIELD_BITS-1:0] field_in [DTV_NUM_FIELDS];
   logic                  err_ff, err_in;
   logic                  ended_ff, ended_in;
   logic                  text_ok;

   logic                  accept;
   logic [7:0]            text_byte;
   logic [7:0]            sep_char;
   logic                  is_space;
   logic                  is_sep;
   logic                  digit_char;
   logic [FIELD_BITS-1:0] acc_base;
   logic [WIDE-1:0]       acc_wide;
   logic [2:0]            fidx;

   assign req_chan.ready = !rec_valid_ff || rec_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign text_byte      = req_chan.text_byte;

   always_comb begin
      word_cnt_in = word_cnt_ff;
      tok_cnt_in  = tok_cnt_ff;
      in_tok_in   = in_tok_ff;
      in_word_in  = in_word_ff;
      acc_in      = acc_ff;
      field_in    = field_ff;
      err_in      = err_ff;
      ended_in    = ended_ff;
      is_space    = 1'b0;
      is_sep      = 1'b0;
      fidx        = DTV_FLD_HOUR;

      sep_char   = (word_cnt_ff == 2'd0) ? DTV_CHAR_COLON : DTV_CHAR_DOT;
      digit_char = (text_byte > DTV_DIGIT_LOW) && (text_byte < DTV_DIGIT_HIGH);
      acc_base   = in_tok_ff ? acc_ff : '0;
      // acc * 10 + digit; the low nibble of an ASCII digit is its value
      acc_wide = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
               + WIDE'(text_byte[3:0]);

      if (!ended_ff) begin
         if (text_byte == DTV_CHAR_NUL) begin
            ended_in = 1'b1;
         end else if (text_byte == DTV_CHAR_SPACE) begin
            is_space = 1'b1;
         end else begin
            in_word_in = 1'b1;
            if (text_byte == sep_char) begin
               is_sep = 1'b1;
            end else begin
               in_tok_in = 1'b1;
               acc_in    = acc_base;
               if (digit_char) begin
                  if (|acc_wide[WIDE-1:FIELD_BITS]) begin
                     acc_in = '1;
                     err_in = 1'b1;
                  end else begin
                     acc_in = acc_wide[FIELD_BITS-1:0];
                  end
               end else begin
                  err_in = 1'b1;
               end
            end
         end
      end

      // Close the open token: a separator, a space or the end of the text
      if (in_tok_in && (is_sep || is_space || req_chan.last)) begin
         in_tok_in = 1'b0;
         if (word_cnt_in == 2'd0 && tok_cnt_in < 3'd2) begin
            fidx = tok_cnt_in;
            field_in[fidx] = acc_in;
         end else if (word_cnt_in == 2'd1 && tok_cnt_in < 3'd3) begin
            fidx = tok_cnt_in + DTV_FLD_DAY;
            field_in[fidx] = acc_in;
         end
         if (tok_cnt_in != 3'd7) begin
            tok_cnt_in = tok_cnt_in + 3'd1;
         end
      end

      // Close the open word and check its token count
      if (in_word_in && (is_space || req_chan.last)) begin
         in_word_in = 1'b0;
         case (word_cnt_in)
            2'd0:    if (tok_cnt_in != 3'd2) err_in = 1'b1;
            2'd1:    if (tok_cnt_in != 3'd3) err_in = 1'b1;
            default: err_in = 1'b1;
         endcase
         if (word_cnt_in != 2'd3) begin
            word_cnt_in = word_cnt_in + 2'd1;
         end
         tok_cnt_in = 3'd0;
      end

      text_ok = !err_in && (word_cnt_in == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff  <= 2'd0;
         tok_cnt_ff   <= 3'd0;
         in_tok_ff    <= 1'b0;
         in_word_ff   <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         ended_ff     <= 1'b0;
         rec_valid_ff <= 1'b0;
         for (int i = 0; i < DTV_NUM_FIELDS; i++) begin
            field_ff[i] <= '0;
         end
      end else begin
         if (accept && req_chan.last) begin
            rec_valid_ff <= 1'b1;
         end else if (rec_ready) begin
            rec_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_chan.last) begin
               // end of text: hand the record on and start the next text clean
               word_cnt_ff  <= 2'd0;
               tok_cnt_ff   <= 3'd0;
               in_tok_ff    <= 1'b0;
               in_word_ff   <= 1'b0;
               acc_ff       <= '0;
               err_ff       <= 1'b0;
               ended_ff     <= 1'b0;
               for (int i = 0; i < DTV_NUM_FIELDS; i++) begin
                  field_ff[i] <= '0;
               end
            end else begin
               word_cnt_ff <= word_cnt_in;
               tok_cnt_ff  <= tok_cnt_in;
               in_tok_ff   <= in_tok_in;
               in_word_ff  <= in_word_in;
               acc_ff      <= acc_in;
               err_ff      <= err_in;
               ended_ff    <= ended_in;
               field_ff    <= field_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.last) begin
         rec_ok_ff    <= text_ok;
         rec_field_ff <= field_in;
      end
   end

endmodule

// ----- rtl/dtv_check.sv -----
// Range checker: validates hour, minute, month and day (with Gregorian leap years)
// and registers the result transaction. Depends on dtv_pkg and dtv_rsp_if.
module dtv_check #(
   parameter int FIELD_BITS = dtv_pkg::DTV_FIELD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rec_valid,
   input  logic                  rec_ok,
   input  logic [FIELD_BITS-1:0] rec_field [dtv_pkg::DTV_NUM_FIELDS],
   output logic                  rec_ready,
   dtv_rsp_if.source             rsp_chan
);
   import dtv_pkg::*;

   localparam int          YW       = (FIELD_BITS > DTV_YEAR_W) ? FIELD_BITS : DTV_YEAR_W;
   localparam logic [63:0] FMAX     = (64'd1 << FIELD_BITS) - 64'd1;
   localparam logic [FIELD_BITS-1:0] INV25 =
      FIELD_BITS'(dtv_odd_inverse(64'(DTV_CENTURY_ODD)));
   localparam logic [FIELD_BITS-1:0] LIM25 = FIELD_BITS'(FMAX / 64'(DTV_CENTURY_ODD));

   logic [FIELD_BITS-1:0] hour, minute, day, month, year;
   logic [FIELD_BITS-1:0] year_mul;
   logic                  div25, leap;
   logic [4:0]            days;
   logic                  month_ok, all_ok;
   logic [YW-1:0]         year_off;

   logic                  out_valid_ff;
   logic                  valid_res_ff;
   logic [4:0]            hour_ff;
   logic [5:0]            minute_ff;
   logic [4:0]            day_ff;
   logic [3:0]            month_ff;
   logic [16:0]           year_ff;

   assign hour   = rec_field[DTV_FLD_HOUR];
   assign minute = rec_field[DTV_FLD_MINUTE];
   assign day    = rec_field[DTV_FLD_DAY];
   assign month  = rec_field[DTV_FLD_MONTH];
   assign year   = rec_field[DTV_FLD_YEAR];

   // Divisible by 25 exactly when year * inverse(25) mod 2^N stays at or below (2^N-1)/25
   assign year_mul = year * INV25;
   assign div25    = (year_mul <= LIM25);
   assign leap     = (year[1:0] == 2'd0) && (!div25 || year[3:0] == 4'd0);

   assign month_ok = (month >= FIELD_BITS'(1)) && (month <= FIELD_BITS'(DTV_MONTHS));
   always_comb begin
      days = dtv_month_days(month[3:0]);
      if (month == FIELD_BITS'(DTV_FEBRUARY) && leap) begin
         days = days + 5'd1;
      end
   end

   assign all_ok = rec_ok
                && (hour <= FIELD_BITS'(DTV_MAX_HOUR))
                && (minute <= FIELD_BITS'(DTV_MAX_MINUTE))
                && month_ok
                && (day >= FIELD_BITS'(1))
                && (day <= FIELD_BITS'(days));

   assign year_off = YW'(year) - YW'(DTV_YEAR_BASE);

   assign rec_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rec_ready) begin
         out_valid_ff <= rec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_valid && rec_ready) begin
         valid_res_ff <= all_ok;
         if (all_ok) begin
            hour_ff   <= hour[4:0];
            minute_ff <= minute[5:0];
            day_ff    <= day[4:0];
            month_ff  <= month[3:0] - 4'd1;
            year_ff   <= year_off[16:0];
         end else begin
            hour_ff   <= '0;
            minute_ff <= '0;
            day_ff    <= '0;
            month_ff  <= '0;
            year_ff   <= '0;
         end
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.valid_res        = valid_res_ff;
   assign rsp_chan.hour             = hour_ff;
   assign rsp_chan.minute           = minute_ff;
   assign rsp_chan.day_of_month     = day_ff;
   assign rsp_chan.month_index      = month_ff;
   assign rsp_chan.years_since_1900 = $signed(year_ff);

endmodule

// ----- rtl/datetime_text_validator_core.sv -----
// Date-time text validator, top level.
// Input (req_chan): one byte of "HH:MM DD.MM.YYYY" per transaction, with last
// marking the final byte. A zero byte ends the text early; the following bytes
// up to the one marked last are ignored.
// Output (rsp_chan): one transaction per text, carrying valid_res and the parsed
// hour, minute, day, month index and year offset from 1900 (all zero if invalid).
// Throughput: one byte per cycle while req_chan.ready is high (it drops under
// rsp_chan back-pressure); the tokenizer state updates in the cycle a byte is
// accepted, and the range checks take one more register stage.
// Result path: the edge that accepts the last byte loads the record register,
// which moves into the result register driving rsp_chan once that one is free.
// Stalls: the result register holds while rsp_chan.ready is low; one more record
// can wait behind it, and req_chan.ready drops only when both are full.
// Reset (synchronous, active high): clears the tokenizer and both valid flags;
// the next byte starts a new text.
// Depends on dtv_pkg, dtv_req_if, dtv_rsp_if, dtv_parser and dtv_check.
module datetime_text_validator_core #(
   parameter int FIELD_BITS = dtv_pkg::DTV_FIELD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   dtv_req_if.sink    req_chan,
   dtv_rsp_if.source  rsp_chan
);
   import dtv_pkg::*;

   logic                  rec_valid;
   logic                  rec_ok;
   logic                  rec_ready;
   logic [FIELD_BITS-1:0] rec_field [DTV_NUM_FIELDS];

   dtv_parser #(
      .FIELD_BITS (FIELD_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rec_valid_ff (rec_valid),
      .rec_ok_ff    (rec_ok),
      .rec_field_ff (rec_field),
      .rec_ready    (rec_ready)
   );

   dtv_check #(
      .FIELD_BITS (FIELD_BITS)
   ) u_check (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec_ok    (rec_ok),
      .rec_field (rec_field),
      .rec_ready (rec_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- test/tb_datetime_text_validator_core.sv -----
// Testbench for datetime_text_validator_core: sends date-time text one byte per
// transaction and compares every result with an in-bench model of the parser and checker.
// Depends on dtv_pkg, dtv_req_if, dtv_rsp_if and the core RTL.
module tb_datetime_text_validator_core;
   import dtv_pkg::*;

   localparam int          RANDOM_BYTES   = 940;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int unsigned FIELD_MAX      = (1 << DTV_FIELD_BITS) - 1;
   localparam logic [7:0]  CHAR_ZERO      = 8'h30;
   localparam logic [7:0]  CHAR_TAB       = 8'h09;

   typedef logic [7:0] byte_seq_type[$];

   typedef struct packed {
      logic        ok;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [16:0] year;
   } datetime_type;

   typedef enum {SINK_OPEN, SINK_RANDOM, SINK_BLOCKED, SINK_TOGGLE} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;

   dtv_req_if req_chan ();
   dtv_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   datetime_text_validator_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   // Parser model state
   logic [1:0]                words_done;
   logic [2:0]                tokens_in_word;
   logic                      in_token;
   logic                      in_word;
   logic [DTV_FIELD_BITS:0]   digit_acc;
   logic [DTV_FIELD_BITS-1:0] field_vals [DTV_NUM_FIELDS];
   logic                      parse_error;
   logic                      text_done;

   datetime_type  expected_dates[$];
   byte_seq_type  text_buf;
   int unsigned   parsed_bytes = 0;
   int            mismatches = 0;
   int            burst_left = 0;
   int            idle_cycles = 0;
   int            stall_left = 0;
   sink_mode_type sink_mode = SINK_OPEN;

   function automatic void clear_parser();
      words_done     = '0;
      tokens_in_word = '0;
      in_token       = 1'b0;
      in_word        = 1'b0;
      digit_acc      = '0;
      parse_error    = 1'b0;
      text_done      = 1'b0;
      foreach (field_vals[i]) field_vals[i] = '0;
   endfunction

   function automatic void close_token();
      if (!in_token) return;
      in_token = 1'b0;
      if (words_done == 2'd0 && tokens_in_word < 3'd2)
         field_vals[DTV_FLD_HOUR + tokens_in_word] = digit_acc[DTV_FIELD_BITS-1:0];
      else if (words_done == 2'd1 && tokens_in_word < 3'd3)
         field_vals[DTV_FLD_DAY + tokens_in_word] = digit_acc[DTV_FIELD_BITS-1:0];
      if (tokens_in_word < 3'd7) tokens_in_word++;
   endfunction

   function automatic void close_word();
      close_token();
      if (!in_word) return;
      in_word = 1'b0;
      case (words_done)
         2'd0: if (tokens_in_word != 3'd2) parse_error = 1'b1;
         2'd1: if (tokens_in_word != 3'd3) parse_error = 1'b1;
         default: parse_error = 1'b1;
      endcase
      if (words_done < 2'd3) words_done++;
      tokens_in_word = '0;
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      logic [7:0]  sep;
      int unsigned grown;
      if (b == DTV_CHAR_NUL) begin
         text_done = 1'b1;
         return;
      end
      if (b == DTV_CHAR_SPACE) begin
         close_word();
         return;
      end
      in_word = 1'b1;
      sep = (words_done == 2'd0) ? DTV_CHAR_COLON : DTV_CHAR_DOT;
      if (b == sep) begin
         close_token();
         return;
      end
      if (!in_token) begin
         in_token  = 1'b1;
         digit_acc = '0;
      end
      if (b > DTV_DIGIT_LOW && b < DTV_DIGIT_HIGH) begin
         grown = digit_acc * 10 + (b - CHAR_ZERO);
         if (grown > FIELD_MAX) begin
            grown       = FIELD_MAX;
            parse_error = 1'b1;
         end
         digit_acc = grown[DTV_FIELD_BITS:0];
      end else begin
         parse_error = 1'b1;
      end
   endfunction

   function automatic int days_in_month(logic [15:0] mo, logic [15:0] yr);
      logic leap;
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      case (mo)
         16'd4, 16'd6, 16'd9, 16'd11: return 30;
         16'(DTV_FEBRUARY):           return leap ? 29 : 28;
         default:                     return 31;
      endcase
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic is_last);
      logic [15:0]  h, mi, d, mo, yr;
      logic         ok;
      datetime_type r;
      if (!text_done) begin
         parsed_bytes++;
         absorb_byte(b);
      end
      if (!is_last) return;
      close_word();
      h  = field_vals[DTV_FLD_HOUR];
      mi = field_vals[DTV_FLD_MINUTE];
      d  = field_vals[DTV_FLD_DAY];
      mo = field_vals[DTV_FLD_MONTH];
      yr = field_vals[DTV_FLD_YEAR];
      ok = !parse_error && words_done == 2'd2 && h <= DTV_MAX_HOUR && mi <= DTV_MAX_MINUTE
           && mo >= 1 && mo <= DTV_MONTHS && d >= 1;
      if (ok && d > days_in_month(mo, yr)) ok = 1'b0;
      r = '0;
      if (ok) begin
         r.ok     = 1'b1;
         r.hour   = h[4:0];
         r.minute = mi[5:0];
         r.day    = d[4:0];
         r.month  = mo[3:0] - 4'd1;
         r.year   = {1'b0, yr} - 17'(DTV_YEAR_BASE);
      end
      expected_dates = {expected_dates, r};
      clear_parser();
   endfunction

   // ---------------------------------------------------------------- sender

   task automatic send_byte(logic [7:0] b, logic is_last);
      req_chan.valid     <= 1'b1;
      req_chan.text_byte <= b;
      req_chan.last      <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      predict_byte(b, is_last);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic send_buf();
      foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   // Always waits on the clock before checking, so valid is never lowered and raised in one step
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_dates.size() != 0);
   endtask

   function automatic void add_byte(logic [7:0] b);
      text_buf = {text_buf, b};
   endfunction

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   task automatic send_str(string s);
      add_str(s);
      send_buf();
   endtask

   function automatic void add_number(int unsigned v);
      int zeros;
      zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
      repeat (zeros) add_byte(CHAR_ZERO);
      add_str($sformatf("%0d", v));
   endfunction

   // One or, now and then, two separators so that empty tokens show up
   function automatic void add_sep(logic [7:0] sep);
      add_byte(sep);
      if ($urandom_range(0, 11) == 0) add_byte(sep);
   endfunction

   function automatic void build_date_text();
      int unsigned vals [DTV_NUM_FIELDS];
      int          n_time, n_date, pos;
      vals[DTV_FLD_HOUR]   = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 23)
                                                         : $urandom_range(24, 199);
      vals[DTV_FLD_MINUTE] = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 59)
                                                         : $urandom_range(60, 199);
      if ($urandom_range(0, 3) == 0) begin
         vals[DTV_FLD_MONTH] = DTV_FEBRUARY;
         vals[DTV_FLD_DAY]   = $urandom_range(27, 30);
      end else begin
         vals[DTV_FLD_MONTH] = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                             : ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
         vals[DTV_FLD_DAY]   = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 31)
                             : ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(32, 99);
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: vals[DTV_FLD_YEAR] = $urandom_range(1890, 2110);
         4, 5:       vals[DTV_FLD_YEAR] = $urandom_range(0, 655) * 100;
         6:          vals[DTV_FLD_YEAR] = $urandom_range(0, 99);
         7, 8:       vals[DTV_FLD_YEAR] = $urandom_range(0, FIELD_MAX);
         default:    vals[DTV_FLD_YEAR] = $urandom_range(FIELD_MAX + 1, 999999);
      endcase
      case ($urandom_range(0, 11))
         0:       n_time = 1;
         1:       n_time = 3;
         default: n_time = 2;
      endcase
      case ($urandom_range(0, 11))
         0:       n_date = 2;
         1:       n_date = 4;
         default: n_date = 3;
      endcase

      if ($urandom_range(0, 9) == 0) add_str("  ");
      if ($urandom_range(0, 19) == 0) add_byte(DTV_CHAR_COLON);
      for (int k = 0; k < n_time; k++) begin
         if (k > 0) add_sep(DTV_CHAR_COLON);
         add_number(vals[(k < 2) ? DTV_FLD_HOUR + k : DTV_FLD_MINUTE]);
      end
      add_byte(DTV_CHAR_SPACE);
      if ($urandom_range(0, 7) == 0) add_str("  ");
      for (int k = 0; k < n_date; k++) begin
         if (k > 0) add_sep(DTV_CHAR_DOT);
         add_number(vals[(k < 3) ? DTV_FLD_DAY + k : DTV_FLD_DAY]);
      end
      if ($urandom_range(0, 19) == 0) add_byte(DTV_CHAR_DOT);
      if ($urandom_range(0, 14) == 0) begin
         add_byte(DTV_CHAR_SPACE);
         add_number($urandom_range(0, 99));
      end
      if ($urandom_range(0, 9) == 0) add_byte(DTV_CHAR_SPACE);

      if ($urandom_range(0, 5) == 0) begin
         pos = $urandom_range(0, text_buf.size() - 1);
         case ($urandom_range(0, 2))
            0:       text_buf[pos] = 8'($urandom_range(0, 255));
            1:       text_buf.insert(pos, DTV_CHAR_NUL);
            default: text_buf[pos] = CHAR_TAB;
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_well_formed();
      send_str("00:00 01.01.0");
      send_str("23:59 31.12.65535");
      send_str("12:34 15.06.2024");
      send_str("7:5 3.4.1999");
      send_str("::08::30:: ..15..08..2001..");
      send_str("  09:15   20.10.1980  ");
      wait_for_results();
   endtask

   task automatic test_leap_years();
      send_str("00:00 29.02.2000");
      send_str("00:00 29.02.1900");
      send_str("06:00 29.02.2024");
      send_str("06:00 29.02.2023");
      send_str("00:00 31.04.2010");
      send_str("00:00 30.11.2010");
   endtask

   task automatic test_field_limits();
      send_str("24:00 01.01.2000");
      send_str("23:60 01.01.2000");
      send_str("00:00 00.01.2000");
      send_str("00:00 01.00.2000");
      send_str("00:00 01.13.2000");
      send_str("00:00 01.01.65536");
      send_str("00:00 01.01.0000065535");
      send_str("99999:0 1.1.1");
   endtask

   task automatic test_malformed_text();
      send_str("12-34 01.01.2000");
      send_str("12:34\t01.01.2000");
      send_str("12:34");
      send_str("12:34 01.01");
      send_str("12:34:56 01.01.2000");
      send_str("12:34 01.01.2000 7");
      send_str("12.34 01:01:2000");
      send_str(" ");
      send_str("5");
   endtask

   task automatic test_early_terminator();
      // terminator mid-stream: the rest up to the last byte is dropped
      add_str("12:34 01.01.2000");
      add_byte(DTV_CHAR_NUL);
      add_str("99 x");
      send_buf();
      add_str("12:34 01.01");
      add_byte(DTV_CHAR_NUL);
      add_str(".2000");
      send_buf();
      add_byte(DTV_CHAR_NUL);
      send_buf();
      add_str("23:59 31.12.1999");
      add_byte(DTV_CHAR_NUL);
      send_buf();
      send_str("8:15 01.02.2003");
      wait_for_results();
   endtask

   task automatic test_random_texts();
      int unsigned start_bytes;
      int          texts;
      string       alphabet;
      start_bytes = parsed_bytes;
      texts       = 0;
      alphabet    = " :.0123456789";
      while (parsed_bytes - start_bytes < RANDOM_BYTES) begin
         case ($urandom_range(0, 19))
            0: repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
            1: repeat ($urandom_range(1, 20))
                  add_byte(alphabet[$urandom_range(0, alphabet.len() - 1)]);
            default: build_date_text();
         endcase
         send_buf();
         texts++;
         if (texts % 30 == 0) wait_for_results();
      end
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void compare_field(string name, logic signed [31:0] want,
                                         logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      datetime_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_dates.size() == 0) begin
            $display("%0t: result transaction with nothing expected", $time);
            mismatches++;
         end else begin
            want = expected_dates.pop_front();
            compare_field("valid_res", 32'(want.ok), 32'(rsp_chan.valid_res));
            compare_field("hour", 32'(want.hour), 32'(rsp_chan.hour));
            compare_field("minute", 32'(want.minute), 32'(rsp_chan.minute));
            compare_field("day_of_month", 32'(want.day), 32'(rsp_chan.day_of_month));
            compare_field("month_index", 32'(want.month), 32'(rsp_chan.month_index));
            compare_field("years_since_1900", 32'($signed(want.year)),
                          32'($signed(rsp_chan.years_since_1900)));
         end
      end
      // receiver back-pressure: segments of open, random, blocked and toggling ready
      if (stall_left == 0) begin
         sink_mode  = sink_mode_type'($urandom_range(0, 3));
         stall_left = (sink_mode == SINK_BLOCKED) ? $urandom_range(1, 12)
                                                  : $urandom_range(10, 60);
      end
      stall_left--;
      case (sink_mode)
         SINK_OPEN:    sink_ready <= 1'b1;
         SINK_RANDOM:  sink_ready <= 1'($urandom_range(0, 1));
         SINK_BLOCKED: sink_ready <= 1'b0;
         default:      sink_ready <= ~sink_ready;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: watchdog, %0d cycles without a transaction, %0d results outstanding",
               $time, idle_cycles, expected_dates.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.text_byte = '0;
      req_chan.last      = 1'b0;
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_well_formed();
      test_leap_years();
      test_field_limits();
      test_malformed_text();
      test_early_terminator();
      test_random_texts();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- datetime_text_validator_core.f -----
rtl/dtv_pkg.sv
rtl/dtv_req_if.sv
rtl/dtv_rsp_if.sv
rtl/dtv_parser.sv
rtl/dtv_check.sv
rtl/datetime_text_validator_core.sv
test/tb_datetime_text_validator_core.sv
